### rtl/core/pal_pkg.sv
// Shared constants, codes and control types for the positional array list.
// Used by pal_cell, pal_row and positional_array_list_top; no dependencies.
`default_nettype none

package pal_pkg;

    localparam int LIST_DEPTH  = 512;
    localparam int VALUE_WIDTH = 16;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // The addressed cell is brought out through a registered tree of 8-input ORs.
    localparam int TREE_FAN    = 8;
    localparam int TREE_LEVELS = (IDX_W + 2) / 3;
    localparam int TREE_LEAVES = 1 << (3 * TREE_LEVELS);
    localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_END   = 3'd1;
    localparam logic [2:0] REQ_INS_AT    = 3'd2;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [2:0] REQ_DEL_END   = 3'd4;
    localparam logic [2:0] REQ_DEL_AT    = 3'd5;
    localparam logic [2:0] REQ_READ      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef struct packed {
        logic                   ins;
        logic                   del;
        logic [IDX_W-1:0]       at;
        logic [VALUE_WIDTH-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        cell_ctrl_t             shift;
        logic [TREE_LEVELS-1:0] load;
    } row_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/positional_array_list_top.sv
// Top level of the positional array list: request decode, sequencing and output word register.
// Depends on pal_pkg and pal_row (which holds the pal_cell chain).
`default_nettype none

// The list lives in a row of LIST_DEPTH cells, one entry per cell, and every insert or
// remove shifts the affected cells by one place together. One request word is
// processed at a time: after acceptance the row is updated while the addressed
// entry enters a registered tree of 8-input ORs, whose levels are loaded one after
// another. The result word is registered once the last level is loaded and the result
// side is not stalled, and only then can the next request word be taken. Requests that
// cannot be carried out leave the list unchanged and report a status code.

module positional_array_list_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [8:0]  position,
    input  wire logic [15:0] entry_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [15:0] out_value,
    output logic      [1:0]  status,
    output logic      [9:0]  entry_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [pal_pkg::LVL_W-1:0]         lvl_cnt_reg;
    logic [pal_pkg::LVL_W-1:0]         lvl_cnt_next;
    pal_pkg::op_t                      op_reg;
    pal_pkg::op_t                      op_next;
    logic [pal_pkg::IDX_W-1:0]         at_reg;
    logic [pal_pkg::IDX_W-1:0]         at_next;
    logic [pal_pkg::VALUE_WIDTH-1:0]   val_reg;
    logic [pal_pkg::VALUE_WIDTH-1:0]   val_next;
    logic [1:0]                        status_reg;
    logic [1:0]                        status_next;
    logic [pal_pkg::CNT_W-1:0]         count_reg;
    logic [pal_pkg::CNT_W-1:0]         count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [15:0]                       out_value_reg;
    logic [15:0]                       out_value_next;
    logic [1:0]                        out_status_reg;
    logic [1:0]                        out_status_next;
    logic [9:0]                        out_count_reg;
    logic [9:0]                        out_count_next;

    logic                              in_acc;
    logic                              update;
    logic                              full;
    logic                              empty;
    logic [pal_pkg::VALUE_WIDTH-1:0]   pick;
    pal_pkg::row_ctrl_t                row_ctrl;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign full     = (32'(count_reg) >= 32'(pal_pkg::LIST_DEPTH));
    assign empty    = (count_reg == '0);
    assign update   = (state_reg == S_RUN) && (lvl_cnt_reg == '0);

    always_comb
    begin
        op_next     = op_reg;
        at_next     = at_reg;
        val_next    = val_reg;
        status_next = status_reg;
        count_next  = count_reg;
        if (in_acc)
        begin
            op_next     = pal_pkg::OP_NONE;
            at_next     = '0;
            val_next    = pal_pkg::VALUE_WIDTH'(entry_value);
            status_next = pal_pkg::ST_OK;
            case (req_type)
                pal_pkg::REQ_INS_FRONT, pal_pkg::REQ_INS_END, pal_pkg::REQ_INS_AT:
                begin
                    if (full)
                    begin
                        status_next = pal_pkg::ST_FULL;
                    end
                    else if ((req_type == pal_pkg::REQ_INS_AT) &&
                             (32'(position) > 32'(count_reg)))
                    begin
                        status_next = pal_pkg::ST_RANGE;
                    end
                    else
                    begin
                        op_next    = pal_pkg::OP_INS;
                        count_next = pal_pkg::CNT_W'(count_reg + 1'b1);
                        if (req_type == pal_pkg::REQ_INS_END)
                        begin
                            at_next = pal_pkg::IDX_W'(count_reg);
                        end
                        else if (req_type == pal_pkg::REQ_INS_AT)
                        begin
                            at_next = pal_pkg::IDX_W'(position);
                        end
                    end
                end
                pal_pkg::REQ_DEL_FRONT, pal_pkg::REQ_DEL_END, pal_pkg::REQ_DEL_AT,
                pal_pkg::REQ_READ:
                begin
                    if (empty)
                    begin
                        status_next = pal_pkg::ST_EMPTY;
                    end
                    else if (((req_type == pal_pkg::REQ_DEL_AT) ||
                              (req_type == pal_pkg::REQ_READ)) &&
                             (32'(position) >= 32'(count_reg)))
                    begin
                        status_next = pal_pkg::ST_RANGE;
                    end
                    else
                    begin
                        if (req_type == pal_pkg::REQ_READ)
                        begin
                            op_next = pal_pkg::OP_READ;
                        end
                        else
                        begin
                            op_next    = pal_pkg::OP_DEL;
                            count_next = pal_pkg::CNT_W'(count_reg - 1'b1);
                        end
                        if (req_type == pal_pkg::REQ_DEL_END)
                        begin
                            at_next = pal_pkg::IDX_W'(count_reg - 1'b1);
                        end
                        else if (req_type != pal_pkg::REQ_DEL_FRONT)
                        begin
                            at_next = pal_pkg::IDX_W'(position);
                        end
                    end
                end
                default:
                begin
                    op_next = pal_pkg::OP_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        row_ctrl.shift.ins   = update && (op_reg == pal_pkg::OP_INS);
        row_ctrl.shift.del   = update && (op_reg == pal_pkg::OP_DEL);
        row_ctrl.shift.at    = at_reg;
        row_ctrl.shift.value = val_reg;
        for (int k = 0; k < pal_pkg::TREE_LEVELS; k++)
        begin
            row_ctrl.load[k] = (state_reg == S_RUN) &&
                               (lvl_cnt_reg == pal_pkg::LVL_W'(k));
        end
    end

    pal_row u_row (
        .clk  (clk),
        .ctrl (row_ctrl),
        .pick (pick)
    );

    always_comb
    begin
        state_next      = state_reg;
        lvl_cnt_next    = lvl_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next   = S_RUN;
                    lvl_cnt_next = '0;
                end
            end
            S_RUN:
            begin
                if (lvl_cnt_reg == pal_pkg::LVL_W'(pal_pkg::TREE_LEVELS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_cnt_next = pal_pkg::LVL_W'(lvl_cnt_reg + 1'b1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = 10'(count_reg);
                    if ((op_reg == pal_pkg::OP_DEL) || (op_reg == pal_pkg::OP_READ))
                    begin
                        out_value_next = 16'(pick);
                    end
                    else
                    begin
                        out_value_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_cnt_reg   <= '0;
            op_reg        <= pal_pkg::OP_NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_cnt_reg   <= lvl_cnt_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg         <= at_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(pal_pkg::LIST_DEPTH))
        else $error("entry count exceeds list depth");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_RUN) && (lvl_cnt_reg == '0))
        else $error("accepted request did not start the row update");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(count_reg))
        else $error("entry count changed without an accepted request");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the completion state");

endmodule

`default_nettype wire

### rtl/core/pal_cell.sv
// One cell of the list row: holds a single entry and shifts it to or from its neighbors.
// Depends on pal_pkg for widths and the cell control type.
`default_nettype none

module pal_cell (
    input  wire logic                            clk,
    input  wire pal_pkg::cell_ctrl_t             ctrl,
    input  wire logic [pal_pkg::IDX_W-1:0]       idx,
    input  wire logic [pal_pkg::VALUE_WIDTH-1:0] left,
    input  wire logic [pal_pkg::VALUE_WIDTH-1:0] right,
    output logic      [pal_pkg::VALUE_WIDTH-1:0] value,
    output logic      [pal_pkg::VALUE_WIDTH-1:0] sel_value
);

    logic [pal_pkg::VALUE_WIDTH-1:0] entry_reg;
    logic [pal_pkg::VALUE_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (idx == ctrl.at)
            begin
                entry_next = ctrl.value;
            end
            else if (idx > ctrl.at)
            begin
                entry_next = left;
            end
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.at)
            begin
                entry_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value     = entry_reg;
    assign sel_value = (idx == ctrl.at) ? entry_reg : '0;

endmodule

`default_nettype wire

### rtl/core/pal_row.sv
// Row of list cells plus the registered OR tree that brings the addressed entry out.
// Depends on pal_pkg and pal_cell.
`default_nettype none

module pal_row (
    input  wire logic                            clk,
    input  wire pal_pkg::row_ctrl_t              ctrl,
    output logic      [pal_pkg::VALUE_WIDTH-1:0] pick
);

    logic [pal_pkg::VALUE_WIDTH-1:0] entry [pal_pkg::LIST_DEPTH];
    logic [pal_pkg::VALUE_WIDTH-1:0] leaf  [pal_pkg::TREE_LEAVES];
    logic [pal_pkg::VALUE_WIDTH-1:0] node_reg [pal_pkg::TREE_LEVELS][pal_pkg::TREE_LEAVES];

    genvar gj;
    genvar gk;

    generate
        for (gj = 0; gj < pal_pkg::TREE_LEAVES; gj++)
        begin : g_cell
            if (gj < pal_pkg::LIST_DEPTH)
            begin : g_used
                logic [pal_pkg::VALUE_WIDTH-1:0] left_val;
                logic [pal_pkg::VALUE_WIDTH-1:0] right_val;

                if (gj == 0)
                begin : g_first
                    assign left_val = '0;
                end
                else
                begin : g_mid_l
                    assign left_val = entry[gj-1];
                end

                if (gj == pal_pkg::LIST_DEPTH - 1)
                begin : g_last
                    assign right_val = entry[gj];
                end
                else
                begin : g_mid_r
                    assign right_val = entry[gj+1];
                end

                pal_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl.shift),
                    .idx       (pal_pkg::IDX_W'(gj)),
                    .left      (left_val),
                    .right     (right_val),
                    .value     (entry[gj]),
                    .sel_value (leaf[gj])
                );
            end
            else
            begin : g_pad
                assign leaf[gj] = '0;
            end
        end

        for (gk = 0; gk < pal_pkg::TREE_LEVELS; gk++)
        begin : g_lvl
            for (gj = 0; gj < (pal_pkg::TREE_LEAVES >> (3 * (gk + 1))); gj++)
            begin : g_node
                logic [pal_pkg::VALUE_WIDTH-1:0] grp;

                if (gk == 0)
                begin : g_from_leaf
                    always_comb
                    begin
                        grp = '0;
                        for (int c = 0; c < pal_pkg::TREE_FAN; c++)
                        begin
                            grp = grp | leaf[gj*pal_pkg::TREE_FAN + c];
                        end
                    end
                end
                else
                begin : g_from_node
                    always_comb
                    begin
                        grp = '0;
                        for (int c = 0; c < pal_pkg::TREE_FAN; c++)
                        begin
                            grp = grp | node_reg[gk-1][gj*pal_pkg::TREE_FAN + c];
                        end
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (ctrl.load[gk])
                    begin
                        node_reg[gk][gj] <= grp;
                    end
                end
            end
        end
    endgenerate

    assign pick = node_reg[pal_pkg::TREE_LEVELS-1][0];

endmodule

`default_nettype wire
